>>> sv/csa_pkg.sv
// package for the complex siglog activation core
// holds widths, register indexes, reset values, step counts and output limits; no dependencies
package csa_pkg;
	localparam int unsigned DataW = 16;
	localparam int unsigned SumW = 32;
	localparam int unsigned MagW = 16;
	localparam int unsigned DenW = 21;
	localparam int unsigned NumW = 30;
	localparam int unsigned QW = 30;
	localparam int unsigned AddrW = 3;
	localparam logic [DataW-1:0] OffsetReset = 16'd4096;
	localparam logic [DataW-1:0] InvRadiusReset = 16'd4096;
	localparam logic [AddrW-1:0] RegOffset = 3'd0;
	localparam logic [AddrW-1:0] RegInvRadius = 3'd4;
	localparam int unsigned SqrtSteps = 16;
	localparam int unsigned DivSteps = 30;
	localparam logic [QW-1:0] OutMax = 30'd32767;
	localparam logic [QW-1:0] OutMinMag = 30'd32768;
endpackage

>>> sv/csa_stream_if.sv
// valid/ready channel carrying one complex sample or result
// depends on csa_pkg for the data width
interface csa_stream_if;
	logic valid;
	logic ready;
	logic signed [csa_pkg::DataW-1:0] re;
	logic signed [csa_pkg::DataW-1:0] im;
	logic sat;
	modport source (output valid, re, im, sat, input ready);
	modport sink (input valid, re, im, sat, output ready);
endinterface

>>> sv/complex_siglog_activation_core.sv
// complex siglog activation z / (c + |z| * inv_radius), one sample per cycle while the output is taken
// depends on csa_pkg and csa_stream_if
//
// channel  dir  payload
// s_in     in   re, im (Q4.12); sat unused
// m_out    out  re, im (Q2.14), sat
// apb      in   offset_c at 0x0, inv_radius at 0x4
//
// pipeline stages: 1 square, 16 root steps, 1 scale, 1 denominator, 30 divide, 1 output
// one sample accepted every cycle while the output is taken
// a stall at the output freezes every stage; nothing is lost or repeated
// reset clears valid bits and the registers to 1.0
module complex_siglog_activation_core (
	input logic clk,
	input logic arst_n,
	csa_stream_if.sink s_in,
	csa_stream_if.source m_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [csa_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int unsigned SS = csa_pkg::SqrtSteps;
	localparam int unsigned DS = csa_pkg::DivSteps;
	localparam int unsigned QW = csa_pkg::QW;
	localparam int unsigned DW = csa_pkg::DenW;

	logic [15:0] offset_q, invr_q;
	logic adv;

	assign pready = 1'b1;
	assign adv = !m_out.valid || m_out.ready;
	assign s_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= csa_pkg::OffsetReset;
			invr_q <= csa_pkg::InvRadiusReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				csa_pkg::RegOffset: offset_q <= pwdata[15:0];
				csa_pkg::RegInvRadius: invr_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			csa_pkg::RegOffset: prdata = {16'd0, offset_q};
			csa_pkg::RegInvRadius: prdata = {16'd0, invr_q};
			default: prdata = '0;
		endcase
	end

	// stage 1: squares
	logic v_s1;
	logic [31:0] sum_s1;
	logic signed [15:0] re_s1, im_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_in.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= 32'(unsigned'(32'(s_in.re * s_in.re)))
				+ 32'(unsigned'(32'(s_in.im * s_in.im)));
			re_s1 <= s_in.re;
			im_s1 <= s_in.im;
		end
	end

	// root stages: one result bit per stage
	logic [SS:0] v_r;
	logic [33:0] rem_r [SS+1];
	logic [15:0] root_r [SS+1];
	logic [31:0] rad_r [SS+1];
	logic signed [15:0] rre_r [SS+1], rim_r [SS+1];
	assign v_r[0] = v_s1;
	assign rem_r[0] = '0;
	assign root_r[0] = '0;
	assign rad_r[0] = sum_s1;
	assign rre_r[0] = re_s1;
	assign rim_r[0] = im_s1;
	for (genvar k = 0; k < SS; k++) begin : g_root
		logic [33:0] rem_n, trial;
		always_comb begin
			rem_n = {rem_r[k][31:0], rad_r[k][31:30]};
			trial = {16'd0, root_r[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[k+1] <= 1'b0;
			else if (adv) v_r[k+1] <= v_r[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_n >= trial) begin
					rem_r[k+1] <= rem_n - trial;
					root_r[k+1] <= {root_r[k][14:0], 1'b1};
				end else begin
					rem_r[k+1] <= rem_n;
					root_r[k+1] <= {root_r[k][14:0], 1'b0};
				end
				rad_r[k+1] <= {rad_r[k][29:0], 2'b00};
				rre_r[k+1] <= rre_r[k];
				rim_r[k+1] <= rim_r[k];
			end
		end
	end

	// scale and denominator stages
	logic v_s2, v_s3;
	logic [31:0] prod_s2;
	logic [DW-1:0] den_s3;
	logic signed [15:0] re_s2, im_s2, re_s3, im_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_r[SS];
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= root_r[SS] * invr_q;
			re_s2 <= rre_r[SS];
			im_s2 <= rim_r[SS];
			den_s3 <= (DW'(offset_q) + DW'(prod_s2[31:12]) == '0) ? DW'(1)
				: DW'(offset_q) + DW'(prod_s2[31:12]);
			re_s3 <= re_s2;
			im_s3 <= im_s2;
		end
	end

	// restoring divide stages, both parts side by side
	logic [DS:0] v_d;
	logic [DW:0] ra_d [DS+1], rb_d [DS+1];
	logic [QW-1:0] na_d [DS+1], nb_d [DS+1];
	logic [DW-1:0] den_d [DS+1];
	logic [DS:0] nega_d, negb_d;
	assign v_d[0] = v_s3;
	assign ra_d[0] = '0;
	assign rb_d[0] = '0;
	assign na_d[0] = {1'b0, (re_s3[15] ? 16'(-re_s3) : 16'(re_s3)), 13'd0} << 1;
	assign nb_d[0] = {1'b0, (im_s3[15] ? 16'(-im_s3) : 16'(im_s3)), 13'd0} << 1;
	assign den_d[0] = den_s3;
	assign nega_d[0] = re_s3[15];
	assign negb_d[0] = im_s3[15];
	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [DW:0] ta, tb;
		always_comb begin
			ta = {ra_d[k][DW-1:0], na_d[k][QW-1]};
			tb = {rb_d[k][DW-1:0], nb_d[k][QW-1]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[k+1] <= 1'b0;
			else if (adv) v_d[k+1] <= v_d[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (ta >= {1'b0, den_d[k]}) begin
					ra_d[k+1] <= ta - {1'b0, den_d[k]};
					na_d[k+1] <= {na_d[k][QW-2:0], 1'b1};
				end else begin
					ra_d[k+1] <= ta;
					na_d[k+1] <= {na_d[k][QW-2:0], 1'b0};
				end
				if (tb >= {1'b0, den_d[k]}) begin
					rb_d[k+1] <= tb - {1'b0, den_d[k]};
					nb_d[k+1] <= {nb_d[k][QW-2:0], 1'b1};
				end else begin
					rb_d[k+1] <= tb;
					nb_d[k+1] <= {nb_d[k][QW-2:0], 1'b0};
				end
				den_d[k+1] <= den_d[k];
				nega_d[k+1] <= nega_d[k];
				negb_d[k+1] <= negb_d[k];
			end
		end
	end

	// saturation and output register
	logic [15:0] oa, ob;
	logic sa, sb;
	always_comb begin
		sa = nega_d[DS] ? (na_d[DS] > csa_pkg::OutMinMag) : (na_d[DS] > csa_pkg::OutMax);
		sb = negb_d[DS] ? (nb_d[DS] > csa_pkg::OutMinMag) : (nb_d[DS] > csa_pkg::OutMax);
		oa = sa ? (nega_d[DS] ? 16'h8000 : 16'h7fff)
			: (nega_d[DS] ? 16'(-na_d[DS][15:0]) : na_d[DS][15:0]);
		ob = sb ? (negb_d[DS] ? 16'h8000 : 16'h7fff)
			: (negb_d[DS] ? 16'(-nb_d[DS][15:0]) : nb_d[DS][15:0]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_out.valid <= 1'b0;
		else if (adv) m_out.valid <= v_d[DS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_out.re <= oa;
			m_out.im <= ob;
			m_out.sat <= sa || sb;
		end
	end
endmodule

>>> sv/csa_checker.sv
// port-level checks for the complex siglog activation core
// depends on complex_siglog_activation_core ports; bound below
module csa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] out_re,
	input logic [15:0] out_im,
	input logic out_sat,
	input logic pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im)
			&& $stable(out_sat))
		else $error("stalled output changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input blocked while output drains");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_re == 16'h7fff || out_re == 16'h8000
			|| out_im == 16'h7fff || out_im == 16'h8000)
		else $error("saturation flag without a clipped part");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind complex_siglog_activation_core csa_checker u_csa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
	.out_valid(m_out.valid), .out_ready(m_out.ready), .out_re(m_out.re),
	.out_im(m_out.im), .out_sat(m_out.sat), .pready(pready)
);

>>> bench/tb_complex_siglog_activation_core.sv
`timescale 1ns / 1ps
// testbench for the complex siglog activation core: directed table then random samples,
// every result checked against a bit-exact predictor; depends on csa_pkg and csa_stream_if
module tb_complex_siglog_activation_core;
	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic sat;
	} act_t;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [15:0] c;
		logic [15:0] ir;
		bit has_exp;
		act_t exp;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [csa_pkg::AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	csa_stream_if s_in ();
	csa_stream_if m_out ();

	complex_siglog_activation_core dut (
		.clk, .arst_n, .s_in(s_in.sink), .m_out(m_out.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #4 clk = ~clk;

	logic [15:0] offset_c = csa_pkg::OffsetReset;
	logic [15:0] inv_radius = csa_pkg::InvRadiusReset;
	act_t pending_act[$];
	int errors = 0;
	int cycles = 0;
	bit hold_long = 0;

	initial begin
		s_in.valid = 0;
		s_in.re = '0;
		s_in.im = '0;
		s_in.sat = 0;
		m_out.ready = 0;
	end

	function automatic logic [31:0] isqrt(logic [31:0] v);
		logic [32:0] r;
		logic [32:0] b;
		logic [32:0] x;
		r = 0;
		x = v;
		b = 33'h1_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [15:0] div_part(logic signed [15:0] p, logic [31:0] den,
			inout logic sat);
		logic [31:0] m;
		logic [47:0] q;
		m = p < 0 ? -32'(p) : 32'(p);
		q = {m, 14'd0} / den;
		if (p < 0) begin
			if (q > 32768) begin
				q = 32768;
				sat = 1;
			end
			return -q[15:0];
		end
		if (q > 32767) begin
			q = 32767;
			sat = 1;
		end
		return q[15:0];
	endfunction

	function automatic act_t siglog(logic signed [15:0] re, logic signed [15:0] im);
		logic [31:0] sumsq;
		logic [31:0] mag;
		logic [31:0] den;
		logic sat;
		act_t a;
		sumsq = 32'(32'(re) * 32'(re)) + 32'(32'(im) * 32'(im));
		mag = isqrt(sumsq);
		den = 32'(offset_c) + ((mag * 32'(inv_radius)) >> 12);
		if (den == 0) den = 1;
		sat = 0;
		a.re = div_part(re, den, sat);
		a.im = div_part(im, den, sat);
		a.sat = sat;
		return a;
	endfunction

	task automatic apb_write(logic [csa_pkg::AddrW-1:0] addr, logic [15:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == csa_pkg::RegOffset) offset_c = val;
		else inv_radius = val;
	endtask

	task automatic set_regs(logic [15:0] c, logic [15:0] ir);
		s_in.valid <= 0;
		while (pending_act.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (c != offset_c) apb_write(csa_pkg::RegOffset, c);
		if (ir != inv_radius) apb_write(csa_pkg::RegInvRadius, ir);
	endtask

	task automatic send(logic signed [15:0] re, logic signed [15:0] im);
		int g;
		if ($urandom_range(0, 3) == 0) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			s_in.valid <= 0;
			repeat (g) @(posedge clk);
		end
		s_in.valid <= 1;
		s_in.re <= re;
		s_in.im <= im;
		pending_act.push_back(siglog(re, im));
		@(posedge clk);
		while (!s_in.ready) @(posedge clk);
	endtask

	task automatic idle_in();
		s_in.valid <= 0;
		@(posedge clk);
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_out.ready <= 0;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			if ($urandom_range(0, 4) == 0) begin
				g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
				m_out.ready <= 0;
				repeat (g) @(posedge clk);
			end
			m_out.ready <= 1;
			@(posedge clk);
		end
	end

	// check each result transfer
	always @(posedge clk) begin
		act_t e;
		if (arst_n && m_out.valid && m_out.ready) begin
			if (pending_act.size() == 0) begin
				$error("unexpected result re=%0d im=%0d", m_out.re, m_out.im);
				errors++;
			end else begin
				e = pending_act.pop_front();
				if (m_out.re !== e.re) begin
					$error("out_real expected %0d actual %0d", e.re, m_out.re);
					errors++;
				end
				if (m_out.im !== e.im) begin
					$error("out_imag expected %0d actual %0d", e.im, m_out.im);
					errors++;
				end
				if (m_out.sat !== e.sat) begin
					$error("saturated expected %0d actual %0d", e.sat, m_out.sat);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	row_t rows[$];

	function automatic row_t mk(int re, int im, int c, int ir, bit he = 0, int ore = 0,
			int oim = 0, bit os = 0);
		row_t r;
		r.re = 16'(re);
		r.im = 16'(im);
		r.c = 16'(c);
		r.ir = 16'(ir);
		r.has_exp = he;
		r.exp.re = 16'(ore);
		r.exp.im = 16'(oim);
		r.exp.sat = os;
		return r;
	endfunction

	initial begin
		act_t p;
		int n;
		logic [15:0] c, ir;
		rows.push_back(mk(0, 0, 4096, 4096, 1, 0, 0, 0));
		rows.push_back(mk(4096, 0, 4096, 4096, 1, 8192, 0, 0));
		rows.push_back(mk(0, -4096, 4096, 4096, 1, 0, -8192, 0));
		rows.push_back(mk(32767, 32767, 4096, 4096));
		rows.push_back(mk(-32768, -32768, 4096, 4096));
		rows.push_back(mk(-32768, 32767, 4096, 4096));
		rows.push_back(mk(1, -1, 4096, 4096));
		rows.push_back(mk(32767, 0, 1, 0, 1, 32767, 0, 1));
		rows.push_back(mk(-32768, 0, 1, 0, 1, -32768, 0, 1));
		rows.push_back(mk(0, 0, 1, 0, 1, 0, 0, 0));
		rows.push_back(mk(1, 1, 1, 0));
		rows.push_back(mk(-1, 0, 1, 0, 1, -16384, 0, 0));
		rows.push_back(mk(32767, -32768, 1, 0));
		rows.push_back(mk(32767, -32768, 65535, 65535));
		rows.push_back(mk(1, 1, 65535, 65535));
		rows.push_back(mk(-32768, 12345, 65535, 65535));
		rows.push_back(mk(21000, -7000, 65535, 0));
		rows.push_back(mk(-5, 32767, 1, 65535));
		rows.push_back(mk(100, 200, 1, 65535));
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].c != offset_c || rows[i].ir != inv_radius)
				set_regs(rows[i].c, rows[i].ir);
			p = siglog(rows[i].re, rows[i].im);
			if (rows[i].has_exp && p != rows[i].exp) begin
				$error("table row %0d predictor disagrees", i);
				errors++;
			end
			send(rows[i].re, rows[i].im);
		end
		idle_in();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin c = 4096; ir = 4096; end
				1: begin c = 1; ir = 0; end
				2: begin c = 65535; ir = 65535; end
				default: begin c = 16'($urandom_range(1, 65535)); ir = 16'($urandom); end
			endcase
			set_regs(c, ir);
			n = 0;
			while (n < 65) begin
				if (ph == 2 && n == 10) hold_long = 1;
				case ($urandom_range(0, 3))
					0: send(16'($urandom), 16'($urandom));
					1: send(16'($urandom_range(0, 255) - 128),
						16'($urandom_range(0, 255) - 128));
					2: send($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000, 16'($urandom));
					default: send(16'($urandom_range(0, 8191) - 4096),
						16'($urandom_range(0, 8191) - 4096));
				endcase
				n++;
			end
			idle_in();
		end
		while (pending_act.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
